@@ hw/rtl/sset_pkg.sv @@
// shared types and constants for the sorted set union engine
`timescale 1ns / 1ps
`default_nettype none

package sset_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;
  localparam int SIZE_W = 6;
  // tdata widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 3'd0,
    OP_APPEND_A = 3'd1,
    OP_APPEND_B = 3'd2,
    OP_QUERY    = 3'd3,
    OP_UNION    = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_ORDER     = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QUERY,
    S_MERGE,
    S_FLIP,
    S_EMIT,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/sset_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module sset_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_set_union_engine_unit.sv @@
// sorted set union engine: two sorted sets, append, lookup and merging union
// clear, append and unused codes go straight to their response beat;
//   a query walks set A one entry a cycle, then gives its beat
// union: merge makes one compare a cycle on the shared comparator, then the banks swap,
//   then one result beat a cycle while the receiver is ready
// throughput: one item at a time, input ready only while idle
// reset: rst synchronous active high, empties both sets; ram contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_union_engine_unit
  import sset_pkg::*;
#(
  parameter int SET_CAPACITY = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input beat
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] value
  input  wire logic [OP_W-1:0]        s_axis_tuser,  // [2:0] operation
  // result beat
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // [31:0] element, [32] found,
                                                     // [34:33] status, [40:35] size_a,
                                                     // [47:41] zero
  output logic                        m_axis_tlast
);

  localparam int AW = $clog2(SET_CAPACITY);
  localparam int CW = $clog2(SET_CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(SET_CAPACITY);

  state_t state, state_next;

  // set A lives in one of two banks; a union merges into the other and swaps
  logic          a_sel, a_sel_next;
  logic [CW-1:0] count_a, count_a_next;
  logic [CW-1:0] count_b, count_b_next;
  data_t         last_a, last_a_next;     // largest element of each set
  data_t         last_b, last_b_next;
  data_t         val_r, val_r_next;
  logic [CW-1:0] i_idx, i_idx_next;       // A walk, also query and emit index
  logic [CW-1:0] j_idx, j_idx_next;       // B walk
  logic [CW-1:0] n_cnt, n_cnt_next;       // merged element count
  logic          trunc, trunc_next;
  logic          found_r, found_r_next;
  status_t       status_r, status_r_next;

  // output register
  logic              m_valid, m_valid_next;
  data_t             o_element, o_element_next;
  logic              o_found, o_found_next;
  status_t           o_status, o_status_next;
  logic [SIZE_W-1:0] o_size, o_size_next;
  logic              o_last, o_last_next;

  // ram ports
  logic              we0, we1, we_b;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     ra_addr, rb_addr;
  logic [DATA_W-1:0] rd0, rd1, rdb;

  logic    in_acc, out_free;
  op_t     op_in;
  data_t   val_in;
  data_t   a_rd, b_rd, pick;
  logic    a_done, b_done, take_a, take_b;
  logic    q_end, e_last, m_stop;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid || m_axis_tready;
  assign op_in         = op_t'(s_axis_tuser);
  assign val_in        = $signed(s_axis_tdata[DATA_W-1:0]);

  assign a_rd   = a_sel ? $signed(rd1) : $signed(rd0);
  assign b_rd   = $signed(rdb);
  assign a_done = (i_idx >= count_a);
  assign b_done = (j_idx >= count_b);
  // merge ends on a cycle with no write: both walks done, or the buffer full
  assign m_stop = (a_done && b_done) || (n_cnt == CAP);
  assign q_end  = (i_idx == count_a - CW'(1));
  assign e_last = (i_idx == count_a - CW'(1));

  // shared comparator: which head moves, equal heads move together
  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    if (b_done) begin
      take_a = 1'b1;
    end else if (a_done) begin
      take_b = 1'b1;
    end else if (a_rd < b_rd) begin
      take_a = 1'b1;
    end else if (b_rd < a_rd) begin
      take_b = 1'b1;
    end else begin
      take_a = 1'b1;
      take_b = 1'b1;
    end
  end
  assign pick = take_a ? a_rd : b_rd;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (op_in)
            OP_QUERY: state_next = (count_a == '0) ? S_RESP : S_QUERY;
            OP_UNION: state_next = S_MERGE;
            default:  state_next = S_RESP;
          endcase
        end
      end
      S_QUERY: if (q_end) state_next = S_RESP;
      S_MERGE: if (m_stop) state_next = S_FLIP;
      S_FLIP:  state_next = (n_cnt == '0) ? S_RESP : S_EMIT;
      S_EMIT:  if (out_free && e_last) state_next = S_IDLE;
      S_RESP:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and output control
  always_comb begin
    a_sel_next     = a_sel;
    count_a_next   = count_a;
    count_b_next   = count_b;
    last_a_next    = last_a;
    last_b_next    = last_b;
    val_r_next     = val_r;
    i_idx_next     = i_idx;
    j_idx_next     = j_idx;
    n_cnt_next     = n_cnt;
    trunc_next     = trunc;
    found_r_next   = found_r;
    status_r_next  = status_r;
    m_valid_next   = m_valid && !m_axis_tready;
    o_element_next = o_element;
    o_found_next   = o_found;
    o_status_next  = o_status;
    o_size_next    = o_size;
    o_last_next    = o_last;
    we0            = 1'b0;
    we1            = 1'b0;
    we_b           = 1'b0;
    waddr          = '0;
    wdata          = s_axis_tdata[DATA_W-1:0];
    ra_addr        = '0;
    rb_addr        = '0;

    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          val_r_next    = val_in;
          found_r_next  = 1'b0;
          status_r_next = ST_OK;
          i_idx_next    = '0;
          j_idx_next    = '0;
          n_cnt_next    = '0;
          trunc_next    = 1'b0;
          case (op_in)
            OP_CLEAR: begin
              count_a_next = '0;
              count_b_next = '0;
            end
            OP_APPEND_A: begin
              waddr = count_a[AW-1:0];
              if (count_a >= CAP) begin
                status_r_next = ST_FULL;
              end else if (count_a != '0 && val_in <= last_a) begin
                status_r_next = ST_ORDER;
              end else begin
                we0          = !a_sel;
                we1          = a_sel;
                count_a_next = count_a + CW'(1);
                last_a_next  = val_in;
              end
            end
            OP_APPEND_B: begin
              waddr = count_b[AW-1:0];
              if (count_b >= CAP) begin
                status_r_next = ST_FULL;
              end else if (count_b != '0 && val_in <= last_b) begin
                status_r_next = ST_ORDER;
              end else begin
                we_b         = 1'b1;
                count_b_next = count_b + CW'(1);
                last_b_next  = val_in;
              end
            end
            default: ;
          endcase
        end
      end

      S_QUERY: begin
        if (a_rd == val_r) begin
          found_r_next = 1'b1;
        end
        if (!q_end) begin
          i_idx_next = i_idx + CW'(1);
        end
        ra_addr = i_idx_next[AW-1:0];
      end

      S_MERGE: begin
        if (!m_stop) begin
          // write into the bank that is not set A
          we0         = a_sel;
          we1         = !a_sel;
          waddr       = n_cnt[AW-1:0];
          wdata       = pick;
          n_cnt_next  = n_cnt + CW'(1);
          last_a_next = pick;
          if (take_a) i_idx_next = i_idx + CW'(1);
          if (take_b) j_idx_next = j_idx + CW'(1);
        end else if (!(a_done && b_done)) begin
          trunc_next = 1'b1;
        end
        ra_addr = i_idx_next[AW-1:0];
        rb_addr = j_idx_next[AW-1:0];
      end

      S_FLIP: begin
        a_sel_next    = !a_sel;
        count_a_next  = n_cnt;
        i_idx_next    = '0;
        found_r_next  = 1'b0;
        status_r_next = ST_OK;
      end

      S_EMIT: begin
        if (out_free) begin
          m_valid_next   = 1'b1;
          o_element_next = a_rd;
          o_found_next   = 1'b0;
          o_status_next  = trunc ? ST_TRUNCATED : ST_OK;
          o_size_next    = SIZE_W'(count_a);
          o_last_next    = e_last;
          i_idx_next     = i_idx + CW'(1);
        end
        ra_addr = i_idx_next[AW-1:0];
      end

      S_RESP: begin
        if (out_free) begin
          m_valid_next   = 1'b1;
          o_element_next = '0;
          o_found_next   = found_r;
          o_status_next  = status_r;
          o_size_next    = SIZE_W'(count_a);
          o_last_next    = 1'b1;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      a_sel   <= 1'b0;
      count_a <= '0;
      count_b <= '0;
      m_valid <= 1'b0;
    end else begin
      state   <= state_next;
      a_sel   <= a_sel_next;
      count_a <= count_a_next;
      count_b <= count_b_next;
      m_valid <= m_valid_next;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    last_a    <= last_a_next;
    last_b    <= last_b_next;
    val_r     <= val_r_next;
    i_idx     <= i_idx_next;
    j_idx     <= j_idx_next;
    n_cnt     <= n_cnt_next;
    trunc     <= trunc_next;
    found_r   <= found_r_next;
    status_r  <= status_r_next;
    o_element <= o_element_next;
    o_found   <= o_found_next;
    o_status  <= o_status_next;
    o_size    <= o_size_next;
    o_last    <= o_last_next;
  end

  // set A banks share address ports; only the selected bank is ever read
  sset_ram #(.WIDTH(DATA_W), .DEPTH(SET_CAPACITY)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ra_addr),
    .rdata (rd0)
  );

  sset_ram #(.WIDTH(DATA_W), .DEPTH(SET_CAPACITY)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ra_addr),
    .rdata (rd1)
  );

  sset_ram #(.WIDTH(DATA_W), .DEPTH(SET_CAPACITY)) u_set_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rb_addr),
    .rdata (rdb)
  );

  assign m_axis_tvalid = m_valid;
  assign m_axis_tlast  = o_last;
  assign m_axis_tdata  = {(OUT_TDATA_W - DATA_W - 1 - STAT_W - SIZE_W)'(0),
                          o_size, o_status, o_found, o_element};

endmodule

`default_nettype wire

@@ hw/rtl/sset_checker.sv @@
// port level checks for the sorted set union engine, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module sset_checker
  import sset_pkg::*;
#(
  parameter int SET_CAPACITY = 32
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tlast
);

  logic              out_beat;
  logic [STAT_W-1:0] o_status;
  logic [SIZE_W-1:0] o_size;
  logic              o_found;

  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign o_found  = m_axis_tdata[DATA_W];
  assign o_status = m_axis_tdata[DATA_W+STAT_W:DATA_W+1];
  assign o_size   = m_axis_tdata[DATA_W+STAT_W+SIZE_W:DATA_W+STAT_W+1];

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  // one item at a time: input closes after an accepted beat
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // only union beats come without last, and those never carry found or fault codes
  assert property (@(posedge clk) disable iff (rst)
    out_beat && !m_axis_tlast |->
      !o_found && (o_status == ST_OK || o_status == ST_TRUNCATED))
    else $error("non-final beat with wrong flags");

  // a truncated union fills set A
  assert property (@(posedge clk) disable iff (rst)
    out_beat && o_status == ST_TRUNCATED |-> o_size == SIZE_W'(SET_CAPACITY))
    else $error("truncated union below capacity");

  // a hit implies set A is not empty and comes on a last beat
  assert property (@(posedge clk) disable iff (rst)
    out_beat && o_found |-> o_size != '0 && m_axis_tlast)
    else $error("hit reported on empty set");

endmodule

bind sorted_set_union_engine_unit sset_checker #(.SET_CAPACITY(SET_CAPACITY)) u_sset_checker (.*);

`default_nettype wire

@@ tb/sorted_set_union_engine_unit_test.sv @@
// self-checking testbench for the sorted set union engine: directed and random stream traffic
`timescale 1ns / 1ps

module sorted_set_union_engine_unit_test;
  import sset_pkg::*;

  localparam int SET_CAPACITY   = 32;
  localparam int RESET_CYCLES   = 11;
  localparam int ITEM_TARGET    = 380;
  localparam int WATCHDOG_LIMIT = 4000;
  // longest union: full merge walk, bank swap, then one beat per entry
  localparam int DRAIN_CYCLES   = 4 * SET_CAPACITY + 16;

  // codes the block leaves unused, answered with a plain ok beat
  localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

  localparam data_t VALUE_MIN = 32'sh8000_0000;
  localparam data_t VALUE_MAX = 32'sh7fff_ffff;

  // result tdata layout, lowest bit up
  localparam int FOUND_BIT  = DATA_W;
  localparam int STATUS_LSB = FOUND_BIT + 1;
  localparam int SIZE_LSB   = STATUS_LSB + STAT_W;
  localparam int PAD_LSB    = SIZE_LSB + SIZE_W;

  typedef struct {
    data_t                element;
    logic                 found;
    status_t              status;
    logic [SIZE_W-1:0]    size_a;
    logic                 last;
  } result_beat_t;

  // mirror of both sets; queues the beats each accepted item should produce
  class sorted_set_tracker;
    data_t          set_a[SET_CAPACITY];
    data_t          set_b[SET_CAPACITY];
    int unsigned    len_a;
    int unsigned    len_b;
    result_beat_t   expected_beats[$];
    int unsigned    mismatches;

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    function void push_beat(data_t element, logic found, status_t status, logic last);
      result_beat_t beat;
      beat.element = element;
      beat.found   = found;
      beat.status  = status;
      beat.size_a  = len_a[SIZE_W-1:0];
      beat.last    = last;
      expected_beats.push_back(beat);
    endfunction

    // full is reported ahead of an order fault
    function status_t append_value(bit to_b, data_t value);
      int unsigned n;
      data_t       tail;
      n = to_b ? len_b : len_a;
      if (n >= SET_CAPACITY) return ST_FULL;
      if (n > 0) begin
        tail = to_b ? set_b[n-1] : set_a[n-1];
        if (value <= tail) return ST_ORDER;
      end
      if (to_b) begin
        set_b[n] = value;
        len_b++;
      end else begin
        set_a[n] = value;
        len_a++;
      end
      return ST_OK;
    endfunction

    // deduplicating merge of b into a, keeping only the smallest entries on overflow
    function void merge_b_into_a();
      data_t       merged[SET_CAPACITY];
      data_t       pick;
      int unsigned i, j, n;
      bit          truncated;
      i = 0;
      j = 0;
      n = 0;
      truncated = 1'b0;
      while (i < len_a || j < len_b) begin
        if (j >= len_b) begin
          pick = set_a[i];
          i++;
        end else if (i >= len_a) begin
          pick = set_b[j];
          j++;
        end else if (set_a[i] < set_b[j]) begin
          pick = set_a[i];
          i++;
        end else if (set_b[j] < set_a[i]) begin
          pick = set_b[j];
          j++;
        end else begin
          pick = set_a[i];
          i++;
          j++;
        end
        if (n >= SET_CAPACITY) begin
          truncated = 1'b1;
          break;
        end
        merged[n] = pick;
        n++;
      end
      for (int k = 0; k < n; k++) set_a[k] = merged[k];
      len_a = n;
      if (n == 0) begin
        push_beat('0, 1'b0, ST_OK, 1'b1);
      end else begin
        for (int k = 0; k < n; k++)
          push_beat(merged[k], 1'b0, truncated ? ST_TRUNCATED : ST_OK, k + 1 == n);
      end
    endfunction

    function void note_item(logic [OP_W-1:0] code, data_t value);
      status_t st;
      logic    hit;
      case (code)
        OP_CLEAR: begin
          len_a = 0;
          len_b = 0;
          push_beat('0, 1'b0, ST_OK, 1'b1);
        end
        OP_APPEND_A: begin
          st = append_value(1'b0, value);
          push_beat('0, 1'b0, st, 1'b1);
        end
        OP_APPEND_B: begin
          st = append_value(1'b1, value);
          push_beat('0, 1'b0, st, 1'b1);
        end
        OP_QUERY: begin
          hit = 1'b0;
          for (int i = 0; i < len_a; i++)
            if (set_a[i] == value) hit = 1'b1;
          push_beat('0, hit, ST_OK, 1'b1);
        end
        OP_UNION: merge_b_into_a();
        default: push_beat('0, 1'b0, ST_OK, 1'b1);
      endcase
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_beat(logic [OUT_TDATA_W-1:0] beat, logic tlast);
      result_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", beat);
        mismatches++;
        return;
      end
      want = expected_beats.pop_front();
      compare_field("element", want.element, $signed(beat[DATA_W-1:0]));
      compare_field("found", want.found, beat[FOUND_BIT]);
      compare_field("status", want.status, beat[STATUS_LSB +: STAT_W]);
      compare_field("size_a", want.size_a, beat[SIZE_LSB +: SIZE_W]);
      compare_field("padding", 0, beat[OUT_TDATA_W-1:PAD_LSB]);
      compare_field("last", want.last, tlast);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;   // [31:0] value
  logic [OP_W-1:0]         s_axis_tuser = '0;   // [2:0] operation
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;        // [31:0] element, [32] found,
                                                // [34:33] status, [40:35] size_a, [47:41] zero
  logic                    m_axis_tlast;

  sorted_set_tracker tracker = new();
  int unsigned       items_sent = 0;
  int unsigned       sender_gap_pct = 26;
  int unsigned       receiver_stall_pct = 61;
  int unsigned       quiet_cycles = 0;

  sorted_set_union_engine_unit #(
    .SET_CAPACITY(SET_CAPACITY)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_beat(m_axis_tdata, m_axis_tlast);
  end

  // a stuck handshake on either side ends the run
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_set_union_engine_unit_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // idling profile moves with progress: receiver-heavy, sender-heavy, then none
  task automatic send_item(input logic [OP_W-1:0] code, input data_t value);
    if (items_sent < ITEM_TARGET / 3) begin
      sender_gap_pct     = 26;
      receiver_stall_pct = 61;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      sender_gap_pct     = 61;
      receiver_stall_pct = 26;
    end else begin
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
    end
    if ($urandom_range(0, 99) < sender_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= code;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_item(code, value);
    if (code <= OP_UNION) items_sent++;
  endtask

  task automatic send_noise();
    send_item(OP_W'($urandom_range(OP_RESERVED_LAST, OP_CLEAR)), $urandom());
  endtask

  // sorted pool spread over a and b with overlaps, then lookups, unions and faults
  task automatic run_set_sequence();
    longint      pool[$];
    longint      cur;
    longint      step_max;
    int unsigned n;
    int unsigned pick;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 2 * SET_CAPACITY)
                                    : $urandom_range(0, 12);
    if ($urandom_range(0, 1) == 0) begin
      // dense values make equal entries in a and b likely
      step_max = 3;
      cur = longint'($signed($urandom()));
      if (cur + 3 * n > longint'(VALUE_MAX)) cur = longint'(VALUE_MAX) - 3 * n;
    end else begin
      step_max = 64'h1_0000_0000 / (n + 2);
      cur = longint'(VALUE_MIN) + ($urandom() % step_max);
    end
    for (int k = 0; k < n; k++) begin
      pool.push_back(cur);
      cur += 1 + ($urandom() % step_max);
    end
    foreach (pool[k]) begin
      pick = $urandom_range(0, 2);
      if (pick != 1) send_item(OP_APPEND_A, data_t'(pool[k]));
      if (pick != 0) send_item(OP_APPEND_B, data_t'(pool[k]));
      if ($urandom_range(0, 11) == 0) send_noise();
    end
    repeat ($urandom_range(1, 3)) begin
      if (pool.size() > 0 && $urandom_range(0, 1) == 0)
        send_item(OP_QUERY, data_t'(pool[$urandom() % pool.size()]));
      else
        send_item(OP_QUERY, $urandom());
    end
    if ($urandom_range(0, 9) != 0) send_item(OP_UNION, $urandom());
    if ($urandom_range(0, 3) == 0) send_item(OP_UNION, $urandom());
    if ($urandom_range(0, 2) == 0) begin
      // a stale value into a full or ordered set
      send_item(OP_APPEND_A, (pool.size() > 0) ? data_t'(pool[0]) : VALUE_MIN);
      send_item(OP_APPEND_B, (pool.size() > 0) ? data_t'(pool[0]) : VALUE_MIN);
    end
    if (pool.size() > 0) send_item(OP_QUERY, data_t'(pool[pool.size() - 1]));
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: empty sets, extremes, order faults, overlap merge, unused codes
    send_item(OP_CLEAR, '0);
    send_item(OP_QUERY, VALUE_MIN);
    send_item(OP_UNION, '0);
    send_item(OP_APPEND_A, VALUE_MIN);
    send_item(OP_APPEND_A, -1);
    send_item(OP_APPEND_A, 0);
    send_item(OP_APPEND_A, VALUE_MAX);
    send_item(OP_APPEND_A, VALUE_MAX);
    send_item(OP_APPEND_A, 5);
    send_item(OP_APPEND_B, VALUE_MIN);
    send_item(OP_APPEND_B, 5);
    send_item(OP_APPEND_B, 32'sh5555_5555);
    send_item(OP_APPEND_B, VALUE_MAX);
    send_item(OP_APPEND_B, -7);
    send_item(OP_QUERY, -1);
    send_item(OP_QUERY, 7);
    send_item(OP_UNION, '1);
    send_item(OP_RESERVED_FIRST, 32'shAAAA_AAAA);
    send_item(OP_RESERVED_LAST, '1);
    send_item(OP_UNION, '0);
    send_item(OP_QUERY, VALUE_MAX);
    send_item(OP_CLEAR, '1);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        if ($urandom_range(0, 9) != 0) send_item(OP_CLEAR, $urandom());
        run_set_sequence();
      end
    end
    s_axis_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("sorted_set_union_engine_unit_test passed");
    end else begin
      $display("sorted_set_union_engine_unit_test failed");
    end
    $finish;
  end

endmodule
